[rtl/core/ads_pkg.sv]
package ads_pkg;

   localparam int WIDTH_DEF  = 240;
   localparam int HEIGHT_DEF = 160;

   // wide enough for a 1024 x 1024 store
   localparam int ADDR_W_MAX = 20;

   localparam int SHADE_W = 4;
   localparam logic [SHADE_W-1:0] SHADE_MAX = 4'hF;

   localparam int OP_Q_DEPTH  = 2;
   localparam int OUT_Q_DEPTH = 2;

   // request opcodes
   localparam logic [1:0] OP_PLOT  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // classified work kinds
   localparam logic [1:0] KIND_PLOT  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [ADDR_W_MAX-1:0] addr;
      logic                  top_ok;
      logic [SHADE_W-1:0]    amt_tl;
      logic [SHADE_W-1:0]    amt_tr;
      logic [SHADE_W-1:0]    amt_bl;
      logic [SHADE_W-1:0]    amt_br;
      logic [SHADE_W-1:0]    shade;
   } ads_op_type;

   typedef struct packed {
      logic [SHADE_W-1:0] read_shade;
      logic               plotted;
   } ads_rsp_type;

endpackage

[rtl/core/ads_if.sv]
interface ads_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] x_pos;
   logic signed [15:0] y_pos;
   logic [15:0]        pixel_index;
   logic [3:0]         write_shade;

   modport source (output valid, opcode, x_pos, y_pos, pixel_index, write_shade,
                   input ready);
   modport sink (input valid, opcode, x_pos, y_pos, pixel_index, write_shade,
                 output ready);
endinterface

interface ads_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] read_shade;
   logic       plotted;

   modport source (output valid, read_shade, plotted, input ready);
   modport sink (input valid, read_shade, plotted, output ready);
endinterface

[rtl/core/ads_ram.sv]
module ads_ram import ads_pkg::*; #(
   parameter int DATA_W = SHADE_W,
   parameter int DEPTH  = WIDTH_DEF * HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ads_queue.sv]
module ads_queue import ads_pkg::*; #(
   parameter int W     = $bits(ads_op_type),
   parameter int DEPTH = OP_Q_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  logic [W-1:0]               push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output logic [W-1:0]               pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign count      = cnt_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/ads_front.sv]
module ads_front import ads_pkg::*; #(
   parameter int WIDTH  = WIDTH_DEF,
   parameter int HEIGHT = HEIGHT_DEF
) (
   ads_req_if.sink    req_chan,
   input  logic       clear_busy,
   output logic       push_valid,
   input  logic       push_ready,
   output ads_op_type push_data
);

   localparam int DEPTH = WIDTH * HEIGHT;
   localparam int AM    = ADDR_W_MAX;
   localparam logic [15:0] X_MAX = 16'((WIDTH - 2) * 16);
   localparam logic [15:0] Y_MAX = 16'((HEIGHT - 2) * 16);

   logic         x_ok, y_ok, idx_ok;
   logic [11:0]  col, row;
   logic [3:0]   fx, fy, w_top, w_bot, f_left, f_right;
   logic [7:0]   p_tl, p_tr, p_bl, p_br;
   logic [AM-1:0] base;

   assign push_valid     = req_chan.valid && !clear_busy;
   assign req_chan.ready = push_ready && !clear_busy;

   always_comb begin
      x_ok    = !req_chan.x_pos[15] && (unsigned'(req_chan.x_pos) <= X_MAX);
      y_ok    = !req_chan.y_pos[15] && (req_chan.y_pos != '0)
                && (unsigned'(req_chan.y_pos) <= Y_MAX);
      idx_ok  = 32'(req_chan.pixel_index) < 32'(DEPTH);
      col     = req_chan.x_pos[15:4];
      row     = req_chan.y_pos[15:4];
      fx      = req_chan.x_pos[3:0];
      fy      = req_chan.y_pos[3:0];
      w_top   = SHADE_MAX - fy;
      w_bot   = fy;
      f_left  = SHADE_MAX - fx;
      f_right = fx;
      p_tl    = 8'(w_top) * 8'(f_left);
      p_tr    = 8'(w_top) * 8'(f_right);
      p_bl    = 8'(w_bot) * 8'(f_left);
      p_br    = 8'(w_bot) * 8'(f_right);
      base    = AM'(row) * AM'(WIDTH) + AM'(col);

      push_data        = '0;
      push_data.kind   = KIND_NOP;
      push_data.amt_tl = p_tl[7:4];
      push_data.amt_tr = p_tr[7:4];
      push_data.amt_bl = p_bl[7:4];
      push_data.amt_br = p_br[7:4];
      push_data.shade  = req_chan.write_shade;
      push_data.top_ok = (row != '0);
      unique case (req_chan.opcode)
         OP_PLOT: begin
            push_data.addr = base;
            if (x_ok && y_ok) push_data.kind = KIND_PLOT;
         end
         OP_READ: begin
            push_data.addr = AM'(req_chan.pixel_index);
            if (idx_ok) push_data.kind = KIND_READ;
         end
         OP_WRITE: begin
            push_data.addr = AM'(req_chan.pixel_index);
            if (idx_ok) push_data.kind = KIND_WRITE;
         end
         default: begin
            push_data.kind = KIND_NOP;
         end
      endcase
   end

endmodule

[rtl/core/ads_back.sv]
module ads_back import ads_pkg::*; #(
   parameter int WIDTH  = WIDTH_DEF,
   parameter int HEIGHT = HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   output logic       op_ready,
   input  ads_op_type op_data,
   ads_rsp_if.source  rsp_chan,
   output logic       clear_busy
);

   localparam int DEPTH = WIDTH * HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int AM    = ADDR_W_MAX;
   localparam int CW    = $clog2(OUT_Q_DEPTH + 1);
   localparam logic [AM-1:0] OFF_TL = AM'(0) - AM'(WIDTH);
   localparam logic [AM-1:0] OFF_TR = OFF_TL + AM'(1);
   localparam logic [AM-1:0] OFF_BL = AM'(0);
   localparam logic [AM-1:0] OFF_BR = AM'(1);

   typedef struct packed {
      logic [1:0]         kind;
      logic [AM-1:0]      addr;
      logic [SHADE_W-1:0] val;
      logic               last;
      logic               fwd;
      logic [SHADE_W-1:0] fwd_data;
   } ads_uop_type;

   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   ads_op_type    cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [1:0]    step_ff, step_in;
   ads_uop_type   b_ff, b_in;
   logic          b_valid_ff, b_valid_in;

   logic               cur_last, room, issue;
   logic [2:0]         pend;
   logic [AM-1:0]      off, uop_addr;
   logic [SHADE_W-1:0] uop_val;
   logic [SHADE_W-1:0] old_shade, sat_shade, b_wr_data;
   logic [SHADE_W:0]   sum;
   logic               b_wr_en;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [SHADE_W-1:0] ram_wr_data, ram_rd_data;
   logic               out_push, out_push_ready, out_pop_valid, out_pop;
   ads_rsp_type        out_push_data, out_pop_data;
   logic [CW-1:0]      out_cnt;

   ads_ram #(.DATA_W(SHADE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (uop_addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   ads_queue #(.W($bits(ads_rsp_type)), .DEPTH(OUT_Q_DEPTH)) u_out_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (out_push),
      .push_ready (out_push_ready),
      .push_data  (out_push_data),
      .pop_valid  (out_pop_valid),
      .pop_ready  (rsp_chan.ready),
      .pop_data   (out_pop_data),
      .count      (out_cnt)
   );

   assign rsp_chan.valid      = out_pop_valid;
   assign rsp_chan.read_shade = out_pop_data.read_shade;
   assign rsp_chan.plotted    = out_pop_data.plotted;
   assign out_pop             = out_pop_valid && rsp_chan.ready;
   assign clear_busy          = clear_ff;

   // issue side: one pixel access per cycle while the result queue has room and no clearing pass runs
   always_comb begin
      cur_last = (cur_ff.kind != KIND_PLOT) || (step_ff == 2'd3);
      // results already owed to the output queue, net of this cycle's transfer
      pend     = 3'(out_cnt) + 3'(b_valid_ff && b_ff.last) - 3'(out_pop);
      room     = pend < 3'(OUT_Q_DEPTH);
      issue    = cur_valid_ff && !clear_ff && (!cur_last || room);
      op_ready = !clear_ff && (!cur_valid_ff || (issue && cur_last));

      off = '0;
      if (cur_ff.kind == KIND_PLOT) begin
         unique case (step_ff)
            2'd0:    off = OFF_TL;
            2'd1:    off = OFF_TR;
            2'd2:    off = OFF_BL;
            default: off = OFF_BR;
         endcase
      end
      uop_addr = cur_ff.addr + off;

      uop_val = cur_ff.shade;
      if (cur_ff.kind == KIND_PLOT) begin
         case (step_ff)
            2'd0:    uop_val = cur_ff.amt_tl;
            2'd1:    uop_val = cur_ff.amt_tr;
            2'd2:    uop_val = cur_ff.amt_bl;
            default: uop_val = cur_ff.amt_br;
         endcase
      end

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (op_ready && op_valid) begin
         cur_in       = op_data;
         cur_valid_in = 1'b1;
         // skip the row above the top edge
         step_in      = (op_data.kind == KIND_PLOT && !op_data.top_ok) ? 2'd2 : 2'd0;
      end else if (issue && cur_last) begin
         cur_valid_in = 1'b0;
      end else if (issue) begin
         step_in = step_ff + 2'd1;
      end
   end

   // update side: read data arrives; a plot adds and saturates, a write takes its shade; both write back
   always_comb begin
      old_shade = b_ff.fwd ? b_ff.fwd_data : ram_rd_data;
      sum       = (SHADE_W + 1)'(old_shade) + (SHADE_W + 1)'(b_ff.val);
      sat_shade = sum[SHADE_W] ? SHADE_MAX : sum[SHADE_W-1:0];
      b_wr_en   = b_valid_ff && (b_ff.kind == KIND_PLOT || b_ff.kind == KIND_WRITE);
      b_wr_data = (b_ff.kind == KIND_WRITE) ? b_ff.val : sat_shade;

      b_valid_in    = issue;
      b_in.kind     = cur_ff.kind;
      b_in.addr     = uop_addr;
      b_in.val      = uop_val;
      b_in.last     = cur_last;
      // forward a write landing on the address read in the same cycle
      b_in.fwd      = b_wr_en && (b_ff.addr[AW-1:0] == uop_addr[AW-1:0]);
      b_in.fwd_data = b_wr_data;

      ram_wr_en   = clear_ff || b_wr_en;
      ram_wr_addr = clear_ff ? clear_addr_ff : b_ff.addr[AW-1:0];
      ram_wr_data = clear_ff ? '0 : b_wr_data;

      out_push                 = b_valid_ff && b_ff.last;
      out_push_data.read_shade = (b_ff.kind == KIND_READ) ? old_shade : '0;
      out_push_data.plotted    = (b_ff.kind == KIND_PLOT);

      clear_in      = clear_ff && (clear_addr_ff != AW'(DEPTH - 1));
      clear_addr_in = clear_addr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         cur_valid_ff  <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         cur_valid_ff  <= cur_valid_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      step_ff <= step_in;
      b_ff    <= b_in;
   end

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_push_ready)
      else $error("result pushed into a full output queue");

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(issue || b_valid_ff))
      else $error("pixel access during clearing pass");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clear_ff |=> !clear_ff)
      else $error("clearing pass restarted");

   a_top_skip: assert property (@(posedge clock) disable iff (reset)
      (issue && cur_ff.kind == KIND_PLOT && !cur_ff.top_ok) |-> step_ff[1])
      else $error("access to the row above the top edge");

endmodule

[rtl/core/antialiased_dot_splat_unit.sv]
// Dot splat into a framebuffer of 4-bit shades.
// req_chan carries one operation per transfer: plot a 12.4 fixed point point,
// read a pixel or write a pixel. rsp_chan returns exactly one result per
// request, in order: read_shade for reads (zero otherwise) and plotted, set
// when a plot passed clipping.
// A plot adds bilinear weights to up to four pixels with saturation at 15.
// Pixel accesses: one per cycle through the shade store's write and read ports
// while the result queue has room; a plot makes four (two on the top row), a
// read, write or no-op one. A request passes through the request queue, the
// issue stage and the update stage (registered store read) into the result queue.
// Reset starts a clearing pass that zeroes the store one pixel per cycle over
// all WIDTH*HEIGHT pixels (38400 at the default size); req_chan.ready stays low
// until it ends.
// A two-entry request queue and a two-entry result queue decouple the sides:
// when the receiver stalls, pending results are held, the engine pauses before
// the item that would overflow them, and requests back up into the queue.
module antialiased_dot_splat_unit import ads_pkg::*; #(
   parameter int WIDTH  = WIDTH_DEF,
   parameter int HEIGHT = HEIGHT_DEF
) (
   input logic        clock,
   input logic        reset,
   ads_req_if.sink    req_chan,
   ads_rsp_if.source  rsp_chan
);

   logic       push_valid, push_ready;
   ads_op_type push_data;
   logic       op_valid, op_ready;
   ads_op_type op_data;
   logic       clear_busy;

   ads_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
      .req_chan   (req_chan),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ads_queue #(.W($bits(ads_op_type)), .DEPTH(OP_Q_DEPTH)) u_op_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (op_valid),
      .pop_ready  (op_ready),
      .pop_data   (op_data),
      .count      ()
   );

   ads_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op_data    (op_data),
      .rsp_chan   (rsp_chan),
      .clear_busy (clear_busy)
   );

endmodule

[tb/antialiased_dot_splat_unit_test.sv]
`timescale 1ns / 1ps

module antialiased_dot_splat_unit_test;
   import ads_pkg::*;

   localparam int FB_W = WIDTH_DEF;
   localparam int FB_H = HEIGHT_DEF;
   localparam int PIXELS = FB_W * FB_H;
   // no transfer for this long ends the run; covers the clearing pass after reset
   localparam int STALL_LIMIT = 200000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;

   ads_req_if req_chan ();
   ads_rsp_if rsp_chan ();

   antialiased_dot_splat_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [3:0]  shade_mirror [0:PIXELS-1];
   ads_rsp_type splat_results_due [$];
   int          mismatch_count = 0;
   int          rsp_holdoff_cycles = 0;
   bit          steady_flow = 0;
   int          win_col = 0;
   int          win_row = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // saturating add into the mirror; pixels outside the frame are dropped
   function automatic void add_shade(int row, int col, int amount);
      int sum;
      if (row < 0 || row >= FB_H || col < 0 || col >= FB_W) return;
      sum = shade_mirror[row * FB_W + col] + amount;
      shade_mirror[row * FB_W + col] = (sum > 15) ? SHADE_MAX : 4'(sum);
   endfunction

   function automatic ads_rsp_type predict_splat(logic [1:0] op, logic signed [15:0] x,
                                                 logic signed [15:0] y, logic [15:0] idx,
                                                 logic [3:0] shade);
      ads_rsp_type r;
      int col;
      int row;
      int fx;
      int fy;
      int wt;
      r = '0;
      case (op)
         OP_PLOT: begin
            if (x >= 0 && x <= (FB_W - 2) * 16 && y >= 1 && y <= (FB_H - 2) * 16) begin
               col = int'(x) >>> 4;
               row = int'(y) >>> 4;
               fx = int'(x) & 15;
               fy = int'(y) & 15;
               // row above takes 15-fy, own row takes fy
               for (int k = 0; k < 2; k++) begin
                  wt = k ? fy : 15 - fy;
                  add_shade(row - 1 + k, col, (wt * (15 - fx)) >> 4);
                  add_shade(row - 1 + k, col + 1, (wt * fx) >> 4);
               end
               r.plotted = 1'b1;
            end
         end
         OP_READ: begin
            if (idx < PIXELS) r.read_shade = shade_mirror[idx];
         end
         OP_WRITE: begin
            if (idx < PIXELS) shade_mirror[idx] = shade;
         end
         default: ;
      endcase
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_op(input logic [1:0] op, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic [15:0] idx,
                          input logic [3:0] shade);
      if (!steady_flow) begin
         while ($urandom_range(99) < 38) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.x_pos <= x;
      req_chan.y_pos <= y;
      req_chan.pixel_index <= idx;
      req_chan.write_shade <= shade;
      do @(posedge clock); while (!req_chan.ready);
      splat_results_due.push_back(predict_splat(op, x, y, idx, shade));
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      while (splat_results_due.size() != 0) @(negedge clock);
   endtask

   task automatic pick_window();
      case ($urandom_range(4))
         0: begin win_col = 0;         win_row = 0;        end
         1: begin win_col = FB_W - 10; win_row = 0;        end
         2: begin win_col = 0;         win_row = FB_H - 8; end
         3: begin win_col = FB_W - 10; win_row = FB_H - 8; end
         default: begin
            win_col = $urandom_range(FB_W - 10);
            win_row = $urandom_range(FB_H - 8);
         end
      endcase
   endtask

   // mostly plots and accesses packed into a small window so shades pile up
   task automatic send_random_ops(input int count);
      int pick;
      logic [1:0] op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0] idx;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) pick_window();
         pick = $urandom_range(99);
         op = (pick < 45) ? OP_PLOT : (pick < 75) ? OP_READ :
              (pick < 92) ? OP_WRITE : OP_UNUSED;
         if ($urandom_range(4) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
            idx = 16'($urandom);
         end else begin
            x = 16'(win_col * 16 + $urandom_range(10 * 16 - 1));
            y = 16'(win_row * 16 + $urandom_range(8 * 16 - 1));
            idx = 16'((win_row + $urandom_range(7)) * FB_W + win_col + $urandom_range(9));
         end
         send_op(op, x, y, idx, 4'($urandom));
      end
   endtask

   task automatic test_clipping();
      send_op(OP_PLOT, 0, 5 * 16 + 7, 0, 0);
      send_op(OP_PLOT, 16'((FB_W - 2) * 16), 16'((FB_H - 2) * 16), 0, 0);
      send_op(OP_PLOT, 16'((FB_W - 2) * 16 + 1), 100, 0, 0);
      send_op(OP_PLOT, -1, 100, 0, 0);
      send_op(OP_PLOT, 100, 16'((FB_H - 2) * 16 + 1), 0, 0);
      send_op(OP_PLOT, 100, 0, 0, 0);
      send_op(OP_PLOT, 16'sh8000, 16'sh7FFF, 16'hFFFF, 4'hF);
      send_op(OP_PLOT, 16'sh7FFF, 16'sh8000, 0, 0);
      send_op(OP_READ, 0, 0, 16'((FB_H - 3) * FB_W + FB_W - 2), 0);
      send_op(OP_READ, 0, 0, 16'((FB_H - 2) * FB_W + FB_W - 1), 0);
   endtask

   // own row is 0: the row above is off the frame and must be dropped
   task automatic test_top_row();
      send_op(OP_PLOT, 20 * 16 + 5, 15, 0, 0);
      send_op(OP_READ, 0, 0, 20, 0);
      send_op(OP_READ, 0, 0, 21, 0);
   endtask

   task automatic test_saturation();
      repeat (3) send_op(OP_PLOT, 50 * 16, 60 * 16 + 15, 0, 0);
      send_op(OP_READ, 0, 0, 16'(60 * FB_W + 50), 0);
   endtask

   task automatic test_index_range();
      send_op(OP_WRITE, 0, 0, 16'(PIXELS - 1), 4'hA);
      send_op(OP_READ, 0, 0, 16'(PIXELS - 1), 0);
      send_op(OP_WRITE, 0, 0, 16'(PIXELS), 4'h5);
      send_op(OP_READ, 0, 0, 16'(PIXELS), 0);
      send_op(OP_READ, 0, 0, 16'hFFFF, 0);
      send_op(OP_WRITE, 0, 0, 0, 4'h5);
      send_op(OP_READ, 0, 0, 0, 0);
   endtask

   task automatic test_unused_opcode();
      send_op(OP_UNUSED, -1, -1, 16'hFFFF, 4'hF);
   endtask

   // hold the result side off while requests keep coming
   task automatic test_backpressure();
      rsp_holdoff_cycles = 300;
      send_random_ops(30);
      wait_all_results();
   endtask

   task automatic test_steady_stream();
      steady_flow = 1;
      send_random_ops(150);
      steady_flow = 0;
   endtask

   task automatic test_random_mix();
      send_random_ops(300);
      wait_all_results();
      send_random_ops(300);
   endtask

   initial begin
      for (int i = 0; i < PIXELS; i++) shade_mirror[i] = '0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_PLOT;
      req_chan.x_pos = '0;
      req_chan.y_pos = '0;
      req_chan.pixel_index = '0;
      req_chan.write_shade = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_clipping();
      test_top_row();
      test_saturation();
      test_index_range();
      test_unused_opcode();
      wait_all_results();
      test_backpressure();
      test_steady_stream();
      test_random_mix();

      wait_all_results();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0)
         $display("antialiased_dot_splat_unit regression: pass");
      else
         $display("antialiased_dot_splat_unit regression: fail");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_holdoff_cycles--;
         end else if (steady_flow) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 38);
         end
      end
   end

   always @(posedge clock) begin
      ads_rsp_type oldest;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (splat_results_due.size() == 0) begin
            $error("result transfer with nothing outstanding");
            mismatch_count++;
         end else begin
            oldest = splat_results_due.pop_front();
            if (rsp_chan.read_shade !== oldest.read_shade) begin
               $error("read_shade: expected %0d, got %0d", oldest.read_shade,
                      rsp_chan.read_shade);
               mismatch_count++;
            end
            if (rsp_chan.plotted !== oldest.plotted) begin
               $error("plotted: expected %0d, got %0d", oldest.plotted, rsp_chan.plotted);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("antialiased_dot_splat_unit regression: fail");
      $finish;
   end

endmodule

[antialiased_dot_splat_unit.f]
rtl/core/ads_pkg.sv
rtl/core/ads_if.sv
rtl/core/ads_ram.sv
rtl/core/ads_queue.sv
rtl/core/ads_front.sv
rtl/core/ads_back.sv
rtl/core/antialiased_dot_splat_unit.sv
tb/antialiased_dot_splat_unit_test.sv
